@@ sv/mdag_pkg.sv @@
`timescale 1ns / 1ps

package mdag_pkg;

    localparam int ARRAY_ID_W = 4;
    localparam int WORD_W     = 32;
    localparam int SIZE_W     = 16;

    localparam logic [1:0] FUNC_HEADER = 2'd0;
    localparam logic [1:0] FUNC_BOUNDS = 2'd1;
    localparam logic [1:0] FUNC_REF    = 2'd2;

    typedef struct packed {
        logic [1:0]               func;
        logic [ARRAY_ID_W-1:0]    array_id;
        logic [2:0]               dim_sel;
        logic [WORD_W-1:0]        base_addr;
        logic [SIZE_W-1:0]        elem_size;
        logic [3:0]               dim_count;
        logic signed [WORD_W-1:0] lower_bound;
        logic signed [WORD_W-1:0] upper_bound;
        logic signed [WORD_W-1:0] index_value;
        logic                     last;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]     address;
        logic [ARRAY_ID_W-1:0] ref_array_id;
    } res_t;

    typedef struct packed {
        logic accept;
        logic mac;
        logic scale;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic ref_start;
        logic last;
        logic res_busy;
    } status_t;

endpackage

@@ sv/mdag_ctrl.sv @@
`timescale 1ns / 1ps

module mdag_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  mdag_pkg::status_t status,
    output mdag_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_SCALE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        req_ready    = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
                if (req_valid && status.ref_start)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac    = 1'b1;
                state_next = status.last ? ST_SCALE : ST_IDLE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.res_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/mdag_datapath.sv @@
`timescale 1ns / 1ps

module mdag_datapath #(
    parameter int MAX_ARRAYS = 16,
    parameter int MAX_DIMS   = 8,
    parameter int ADDR_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mdag_pkg::req_t    req,
    input  mdag_pkg::cmd_t    cmd,
    output mdag_pkg::status_t status,
    output logic              res_valid,
    input  logic              res_ready,
    output mdag_pkg::res_t    res
);

    localparam int AidW     = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
    localparam int DimW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SlotW    = AidW + DimW;
    localparam int Slots    = 1 << SlotW;
    localparam int IdValues = 1 << mdag_pkg::ARRAY_ID_W;
    localparam logic [DimW-1:0] DimLast = DimW'(MAX_DIMS - 1);
    localparam logic [mdag_pkg::WORD_W-1:0] AddrMask =
        (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_WIDTH) - 64'd1);

    logic [mdag_pkg::WORD_W-1:0] base_mem   [MAX_ARRAYS];
    logic [mdag_pkg::SIZE_W-1:0] size_mem   [MAX_ARRAYS];
    logic [mdag_pkg::WORD_W-1:0] lower_mem  [Slots];
    logic [mdag_pkg::WORD_W-1:0] extent_mem [Slots];

    logic [AidW-1:0]                 aid;
    logic [mdag_pkg::WORD_W-1:0]     base_rd_reg;
    logic [mdag_pkg::SIZE_W-1:0]     size_rd_reg;
    logic [mdag_pkg::WORD_W-1:0]     lower_rd_reg;
    logic [mdag_pkg::WORD_W-1:0]     extent_rd_reg;
    logic [mdag_pkg::WORD_W-1:0]     idx_reg;
    logic                            last_reg;
    logic [mdag_pkg::ARRAY_ID_W-1:0] aid_raw_reg;
    logic [mdag_pkg::WORD_W-1:0]     scale_reg;
    logic [mdag_pkg::WORD_W-1:0]     offset_acc_reg;
    logic [mdag_pkg::WORD_W-1:0]     offset_acc_next;
    logic [DimW-1:0]                 dim_pos_reg;
    logic [DimW-1:0]                 dim_pos_next;
    logic                            res_valid_reg;
    logic                            res_valid_next;
    mdag_pkg::res_t                  res_reg;

    logic write_header;
    logic write_bounds;
    logic start_ref;

    // The array id is reduced modulo the table size through a small constant table.
    always_comb
    begin
        aid = '0;
        for (int i = 0; i < IdValues; i++)
        begin
            if (req.array_id == mdag_pkg::ARRAY_ID_W'(i))
            begin
                aid = AidW'(i % MAX_ARRAYS);
            end
        end
    end

    always_comb
    begin
        write_header = 1'b0;
        write_bounds = 1'b0;
        start_ref    = 1'b0;
        unique case (req.func)
            mdag_pkg::FUNC_HEADER: write_header = cmd.accept;
            mdag_pkg::FUNC_BOUNDS: write_bounds = cmd.accept && (32'(req.dim_sel) < MAX_DIMS);
            mdag_pkg::FUNC_REF:    start_ref    = cmd.accept;
            default:               start_ref    = 1'b0;
        endcase
    end

    assign status.ref_start = (req.func == mdag_pkg::FUNC_REF);
    assign status.last      = last_reg;
    assign status.res_busy  = res_valid_reg && !res_ready;

    always_ff @(posedge clk)
    begin
        if (write_header)
        begin
            base_mem[aid] <= req.base_addr;
            size_mem[aid] <= req.elem_size;
        end
        if (write_bounds)
        begin
            lower_mem[{aid, DimW'(req.dim_sel)}]  <= $unsigned(req.lower_bound);
            extent_mem[{aid, DimW'(req.dim_sel)}] <=
                $unsigned(req.upper_bound) - $unsigned(req.lower_bound) + 32'd1;
        end
        if (start_ref)
        begin
            base_rd_reg   <= base_mem[aid];
            size_rd_reg   <= size_mem[aid];
            lower_rd_reg  <= lower_mem[{aid, dim_pos_reg}];
            extent_rd_reg <= extent_mem[{aid, dim_pos_reg}];
            idx_reg       <= $unsigned(req.index_value);
            last_reg      <= req.last;
            aid_raw_reg   <= req.array_id;
        end
        if (cmd.scale)
        begin
            scale_reg <= 32'(size_rd_reg) * offset_acc_reg;
        end
        if (cmd.load_out)
        begin
            res_reg.address      <= (base_rd_reg + scale_reg) & AddrMask;
            res_reg.ref_array_id <= aid_raw_reg;
        end
    end

    always_comb
    begin
        offset_acc_next = offset_acc_reg;
        dim_pos_next    = dim_pos_reg;
        if (cmd.mac)
        begin
            offset_acc_next = offset_acc_reg * extent_rd_reg + (idx_reg - lower_rd_reg);
            if (!last_reg && (dim_pos_reg != DimLast))
            begin
                dim_pos_next = dim_pos_reg + 1'b1;
            end
        end
        if (cmd.scale)
        begin
            offset_acc_next = '0;
            dim_pos_next    = '0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_acc_reg <= '0;
            dim_pos_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            offset_acc_reg <= offset_acc_next;
            dim_pos_reg    <= dim_pos_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ sv/multidim_array_address_gen.sv @@
`timescale 1ns / 1ps
// Row-major address generator for a table of multidimensional array descriptors.
// Requests arrive on req (req_valid/req_ready); func selects a descriptor header
// write, a dimension bounds write, or one index of an array reference.
// Header and bounds writes produce no result.
// A reference streams one index per request, first dimension first; each index
// takes a descriptor table read, then one multiply-accumulate of the
// running offset on a 32x32 multiplier.
// After the index marked last, the offset is multiplied by the element size, then
// the base is added as the address is loaded into the res output register.
// Results leave on res (res_valid/res_ready). When the receiver stalls, a result
// waits in the output register and new requests are still accepted; a further
// completed reference waits, blocking new requests, until the held result is taken.
// Reset clears the running offset, the dimension position and the output valid.
// Descriptor tables are not cleared and must be written before they are used.
module multidim_array_address_gen #(
    parameter int MAX_ARRAYS = 16,
    parameter int MAX_DIMS   = 8,
    parameter int ADDR_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mdag_pkg::req_t req,
    output logic           res_valid,
    input  logic           res_ready,
    output mdag_pkg::res_t res
);

    mdag_pkg::cmd_t    cmd;
    mdag_pkg::status_t status;

    mdag_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mdag_datapath #(
        .MAX_ARRAYS (MAX_ARRAYS),
        .MAX_DIMS   (MAX_DIMS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!res_valid || res_ready))
        else $error("result register loaded while a result is still held");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.mac, cmd.scale, cmd.load_out}))
        else $error("more than one datapath command in a cycle");

    a_ref_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.func == mdag_pkg::FUNC_REF) |=> !req_ready)
        else $error("request accepted while an index is in progress");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd.load_out))
        else $error("result valid raised without a load");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        mdag_pkg::req_t r;
        bit             drain;
    } pend_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    mdag_pkg::req_t req = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    mdag_pkg::res_t res;

    multidim_array_address_gen dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Request stream, built up front.
    pend_t pend_q[$];
    int    n_items = 0;
    bit    drain_next = 1'b0;
    bit    hdr_ok[16];
    bit    bnd_ok[16][8];
    logic [31:0] gen_lo[16][8];
    logic [31:0] gen_ext[16][8];

    // Expected results and the mirrored descriptor tables.
    mdag_pkg::res_t addr_q[$];
    logic [31:0] base_tbl[16];
    logic [15:0] size_tbl[16];
    logic [31:0] lo_tbl[16][8];
    logic [31:0] ext_tbl[16][8];
    logic [31:0] offset_acc = '0;
    logic [2:0]  dim_pos = '0;

    int mismatches = 0;
    int n_checked = 0;
    int n_hdr = 0;
    int n_bnd = 0;
    int n_idx = 0;
    int n_noise = 0;

    logic [9:0] cyc = '0;
    logic       quiet;
    int         send_gap = 0;
    int         hold_cnt = 0;

    assign quiet = (cyc[9:8] == 2'b11);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic mdag_pkg::req_t junk_req();
        logic [159:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return bits[$bits(mdag_pkg::req_t)-1:0];
    endfunction

    task automatic push_req(input mdag_pkg::req_t r);
        pend_t p;
        p.r = r;
        p.drain = drain_next;
        drain_next = 1'b0;
        pend_q.insert(pend_q.size(), p);
        n_items++;
    endtask

    task automatic push_hdr(input int id, input logic [31:0] base, input logic [15:0] sz,
                            input logic [3:0] dc);
        mdag_pkg::req_t r;
        r = junk_req();
        r.func = mdag_pkg::FUNC_HEADER;
        r.array_id = 4'(id);
        r.base_addr = base;
        r.elem_size = sz;
        r.dim_count = dc;
        hdr_ok[id] = 1'b1;
        push_req(r);
    endtask

    task automatic push_bnd(input int id, input int d, input logic [31:0] lo,
                            input logic [31:0] hi);
        mdag_pkg::req_t r;
        r = junk_req();
        r.func = mdag_pkg::FUNC_BOUNDS;
        r.array_id = 4'(id);
        r.dim_sel = 3'(d);
        r.lower_bound = lo;
        r.upper_bound = hi;
        bnd_ok[id][d] = 1'b1;
        gen_lo[id][d] = lo;
        gen_ext[id][d] = hi - lo + 32'd1;
        push_req(r);
    endtask

    task automatic push_ref(input int id, input logic [31:0] idx, input bit is_last);
        mdag_pkg::req_t r;
        r = junk_req();
        r.func = mdag_pkg::FUNC_REF;
        r.array_id = 4'(id);
        r.index_value = idx;
        r.last = is_last;
        push_req(r);
    endtask

    task automatic push_noise();
        mdag_pkg::req_t r;
        r = junk_req();
        r.func = FUNC_UNUSED;
        push_req(r);
    endtask

    task automatic push_rand_hdr(input int id);
        logic [15:0] sz;
        sz = ($urandom_range(0, 4) == 0) ? 16'd1 : 16'($urandom);
        push_hdr(id, $urandom, sz, 4'($urandom));
    endtask

    task automatic push_rand_bnd(input int id, input int d);
        int          lo;
        int          r;
        logic [31:0] hi;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            lo = $urandom_range(0, 40) - 20;
            hi = lo + $urandom_range(0, 15);
            push_bnd(id, d, lo, hi);
        end
        else if (r < 85)
            push_bnd(id, d, $urandom, $urandom);
        else
            push_bnd(id, d, ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF),
                     ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF));
    endtask

    task automatic gen_reference();
        int          n;
        int          k;
        int          id;
        int          pos;
        int          home;
        logic [31:0] idx;
        home = $urandom_range(0, 15);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 11) : $urandom_range(1, 4);
        for (k = 0; k < n; k++)
        begin
            pos = (k < 7) ? k : 7;
            id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : home;
            if ($urandom_range(0, 11) == 0)
            begin
                if ($urandom_range(0, 1))
                    push_noise();
                else
                    push_rand_hdr($urandom_range(0, 15));
            end
            if (!bnd_ok[id][pos])
                push_rand_bnd(id, pos);
            if (k == n - 1 && !hdr_ok[id])
                push_rand_hdr(id);
            if ($urandom_range(0, 9) < 7)
                idx = (gen_ext[id][pos] == 0) ? $urandom
                                              : gen_lo[id][pos] + ($urandom % gen_ext[id][pos]);
            else
                idx = $urandom;
            push_ref(id, idx, k == n - 1);
        end
    endtask

    task automatic apply_request(input mdag_pkg::req_t r);
        mdag_pkg::res_t e;
        case (r.func)
            mdag_pkg::FUNC_HEADER:
            begin
                base_tbl[r.array_id] = r.base_addr;
                size_tbl[r.array_id] = r.elem_size;
            end
            mdag_pkg::FUNC_BOUNDS:
            begin
                lo_tbl[r.array_id][r.dim_sel] = r.lower_bound;
                ext_tbl[r.array_id][r.dim_sel] = r.upper_bound - r.lower_bound + 32'd1;
            end
            mdag_pkg::FUNC_REF:
            begin
                offset_acc = offset_acc * ext_tbl[r.array_id][dim_pos]
                           + (r.index_value - lo_tbl[r.array_id][dim_pos]);
                if (r.last)
                begin
                    e.address = base_tbl[r.array_id]
                              + {16'd0, size_tbl[r.array_id]} * offset_acc;
                    e.ref_array_id = r.array_id;
                    addr_q.insert(addr_q.size(), e);
                    offset_acc = '0;
                    dim_pos = '0;
                end
                else if (dim_pos != 3'd7)
                    dim_pos = dim_pos + 3'd1;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Driver.
    always @(posedge clk)
    begin : drive
        logic  nxt_valid;
        pend_t p;
        nxt_valid = req_valid;
        if (!rst_n)
            nxt_valid = 1'b0;
        else if (!req_valid || req_ready)
        begin
            nxt_valid = 1'b0;
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pend_q.size() != 0
                     && !(pend_q[0].drain && (req_valid || addr_q.size() != 0)))
            begin
                p = pend_q.pop_front();
                req <= p.r;
                nxt_valid = 1'b1;
                send_gap <= pick_gap();
            end
        end
        req_valid <= nxt_valid;
    end

    // Result receiver with random stalls.
    always @(posedge clk)
    begin
        cyc <= cyc + 10'd1;
        if (!rst_n)
            res_ready <= 1'b0;
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                hold_cnt <= pick_gap();
        end
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge clk)
    begin : watch
        mdag_pkg::res_t e;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                case (req.func)
                    mdag_pkg::FUNC_HEADER: n_hdr++;
                    mdag_pkg::FUNC_BOUNDS: n_bnd++;
                    mdag_pkg::FUNC_REF:    n_idx++;
                    default:               n_noise++;
                endcase
                apply_request(req);
            end
            if (res_valid && res_ready)
            begin
                if (addr_q.size() == 0)
                    report_error($sformatf("unexpected result address=%h id=%0d",
                                           res.address, res.ref_array_id));
                else
                begin
                    e = addr_q.pop_front();
                    n_checked++;
                    if (res.address !== e.address || res.ref_array_id !== e.ref_array_id)
                        report_error($sformatf(
                            "expected address=%h id=%0d, got address=%h id=%0d",
                            e.address, e.ref_array_id, res.address, res.ref_array_id));
                end
            end
        end
    end

    initial
    begin
        int r;
        int id;
        int d;
        int dc;

        // Basic one-dimensional reference.
        push_hdr(0, 32'h0000_1000, 16'd4, 4'd1);
        push_bnd(0, 0, 32'd0, 32'd9);
        push_ref(0, 32'd5, 1'b1);
        // Dimension counts of 0 and 15; the design does not use the count.
        push_hdr(15, 32'hFFFF_FFFF, 16'hFFFF, 4'd0);
        push_hdr(15, 32'hFFFF_FFFF, 16'hFFFF, 4'd15);
        // Extreme bounds, including extents that wrap.
        push_bnd(15, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        push_bnd(15, 1, 32'h7FFF_FFFF, 32'h8000_0000);
        push_bnd(15, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_bnd(15, 3, 32'd0, 32'h7FFF_FFFF);
        for (d = 4; d < 8; d++)
            push_bnd(15, d, -32'sd3, 32'sd4);
        // Nine indices: the last one reuses the final dimension's bounds.
        push_ref(15, 32'h7FFF_FFFF, 1'b0);
        push_ref(15, 32'h8000_0000, 1'b0);
        push_ref(15, 32'hFFFF_FFFF, 1'b0);
        push_ref(15, 32'd0, 1'b0);
        push_ref(15, 32'd4, 1'b0);
        push_ref(15, -32'sd3, 1'b0);
        push_ref(15, 32'd1, 1'b0);
        push_ref(15, 32'd2, 1'b0);
        push_ref(15, 32'h8000_0000, 1'b1);
        push_noise();
        // Mixed array ids, with a bounds write in the middle of the reference.
        push_ref(15, 32'h8000_0000, 1'b0);
        push_bnd(0, 1, -32'sd5, 32'sd5);
        push_ref(0, -32'sd5, 1'b1);
        push_ref(15, 32'd2, 1'b1);

        drain_next = 1'b1;
        while (n_items < 620)
        begin
            if (n_items > 300 && n_items < 310)
                drain_next = 1'b1;
            r = $urandom_range(0, 99);
            id = $urandom_range(0, 15);
            if (r < 10)
            begin
                dc = $urandom_range(1, 8);
                push_rand_hdr(id);
                for (d = 0; d < dc; d++)
                    push_rand_bnd(id, d);
            end
            else if (r < 18)
                push_rand_hdr(id);
            else if (r < 30)
                push_rand_bnd(id, $urandom_range(0, 7));
            else if (r < 35)
                push_noise();
            else
                gen_reference();
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || req_valid || addr_q.size() != 0)
            @(negedge clk);
        repeat (12) @(posedge clk);

        if (addr_q.size() != 0)
            mismatches++;
        $display("Sent %0d requests: %0d header writes, %0d bounds writes,",
                 n_items, n_hdr, n_bnd);
        $display("%0d indices, %0d unused codes; checked %0d addresses, %0d errors.",
                 n_idx, n_noise, n_checked, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out waiting for results.");
        $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
sv/mdag_pkg.sv
sv/mdag_ctrl.sv
sv/mdag_datapath.sv
sv/multidim_array_address_gen.sv
bench/tb.sv
